/* rtl/cbl_pkg.sv */
package cbl_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int NUM_CASES_DEF    = 64;

    localparam int ACTION_W  = 4;
    localparam int ELEM_W    = 10;
    localparam int CASE_W    = 32;
    localparam int NCOUNT_W  = 11;
    localparam int OUTCNT_W  = 11;
    localparam int ERR_W     = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_RESIZE = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_SET    = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_GET    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_COUNT  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_FIRST  = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_NEXT   = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_SWAP   = 4'd8;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CASE  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_IDLE    = 5'd0;
    localparam logic [OP_W-1:0] OP_DECODE  = 5'd1;
    localparam logic [OP_W-1:0] OP_GROW    = 5'd2;
    localparam logic [OP_W-1:0] OP_GET     = 5'd3;
    localparam logic [OP_W-1:0] OP_NEXT    = 5'd4;
    localparam logic [OP_W-1:0] OP_CNT     = 5'd5;
    localparam logic [OP_W-1:0] OP_FIRST   = 5'd6;
    localparam logic [OP_W-1:0] OP_SET_CHK = 5'd7;
    localparam logic [OP_W-1:0] OP_SW_RD2  = 5'd8;
    localparam logic [OP_W-1:0] OP_SW_CHK  = 5'd9;
    localparam logic [OP_W-1:0] OP_A_RD    = 5'd10;
    localparam logic [OP_W-1:0] OP_A_CUR   = 5'd11;
    localparam logic [OP_W-1:0] OP_U_HDR   = 5'd12;
    localparam logic [OP_W-1:0] OP_A_LINK  = 5'd13;
    localparam logic [OP_W-1:0] OP_A_HEAD  = 5'd14;
    localparam logic [OP_W-1:0] OP_A_END   = 5'd15;
    localparam logic [OP_W-1:0] OP_R_CUR   = 5'd16;
    localparam logic [OP_W-1:0] OP_R_MOVE  = 5'd17;
    localparam logic [OP_W-1:0] OP_R_LAST  = 5'd18;
    localparam logic [OP_W-1:0] OP_R_FIX   = 5'd19;
    localparam logic [OP_W-1:0] OP_R_HEAD  = 5'd20;
    localparam logic [OP_W-1:0] OP_FIN     = 5'd21;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic rng1;
        logic rng2;
        logic full;
        logic nc_over;
        logic grow;
        logic grow_last;
        logic cv_zero;
        logic cv_hdr_ok;
        logic set_same;
        logic set_ok;
        logic sw_same;
        logic sw_ok;
        logic cur_same;
        logic cur_hdr;
        logic av_hdr;
        logic last_done;
        logic fix_hdr;
        logic second;
        logic out_free;
    } stat_t;

endpackage

/* rtl/cbl_ctrl.sv */
module cbl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cbl_pkg::stat_t st,
    output cbl_pkg::cmd_t  cmd
);
    import cbl_pkg::*;

    logic [OP_W-1:0] state_reg;
    logic [OP_W-1:0] state_next;

    assign cmd.op   = state_reg;
    assign in_ready = (state_reg == OP_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            OP_IDLE:
            begin
                if (in_valid)
                    state_next = OP_DECODE;
            end
            OP_DECODE:
            begin
                case (st.act)
                    ACT_RESIZE: state_next = (!st.nc_over && st.grow) ? OP_GROW : OP_FIN;
                    ACT_SET:    state_next = st.rng1 ? OP_FIN : OP_SET_CHK;
                    ACT_REMOVE: state_next = st.rng1 ? OP_FIN : OP_R_CUR;
                    ACT_GET:    state_next = st.rng1 ? OP_FIN : OP_GET;
                    ACT_NEXT:   state_next = st.rng1 ? OP_FIN : OP_NEXT;
                    ACT_COUNT:  state_next = (st.cv_zero || !st.cv_hdr_ok) ? OP_FIN : OP_CNT;
                    ACT_FIRST:  state_next = st.cv_hdr_ok ? OP_FIRST : OP_FIN;
                    ACT_SWAP:   state_next = (st.rng1 || st.rng2) ? OP_FIN : OP_SW_RD2;
                    default:    state_next = OP_FIN;
                endcase
            end
            OP_GROW:
            begin
                if (st.grow_last)
                    state_next = OP_FIN;
            end
            OP_GET, OP_NEXT, OP_CNT, OP_FIRST, OP_A_HEAD, OP_R_HEAD:
            begin
                state_next = (state_reg == OP_A_HEAD) ? OP_A_END : OP_FIN;
            end
            OP_SET_CHK:
            begin
                state_next = (st.set_same || !st.set_ok) ? OP_FIN : OP_A_RD;
            end
            OP_SW_RD2: state_next = OP_SW_CHK;
            OP_SW_CHK:
            begin
                state_next = (st.sw_same || !st.sw_ok) ? OP_FIN : OP_A_RD;
            end
            OP_A_RD: state_next = OP_A_CUR;
            OP_A_CUR:
            begin
                if (st.cur_same)
                    state_next = OP_A_END;
                else
                    state_next = st.cur_hdr ? OP_U_HDR : OP_A_LINK;
            end
            OP_U_HDR:
            begin
                state_next = (st.act == ACT_REMOVE) ? OP_R_MOVE : OP_A_LINK;
            end
            OP_A_LINK: state_next = st.av_hdr ? OP_A_HEAD : OP_A_END;
            OP_A_END:  state_next = st.second ? OP_A_RD : OP_FIN;
            OP_R_CUR:  state_next = st.cur_hdr ? OP_U_HDR : OP_R_MOVE;
            OP_R_MOVE: state_next = st.last_done ? OP_FIN : OP_R_LAST;
            OP_R_LAST: state_next = OP_R_FIX;
            OP_R_FIX:  state_next = st.fix_hdr ? OP_R_HEAD : OP_FIN;
            OP_FIN:
            begin
                if (st.out_free)
                    state_next = OP_IDLE;
            end
            default: state_next = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= OP_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/cbl_dp.sv */
module cbl_dp #(
    parameter int MAX_ELEMENTS = cbl_pkg::MAX_ELEMENTS_DEF,
    parameter int NUM_CASES    = cbl_pkg::NUM_CASES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [cbl_pkg::CASE_W-1:0]         cfg_data,
    input  logic                               in_valid,
    input  logic [cbl_pkg::IN_DATA_W-1:0]      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cbl_pkg::OUT_DATA_W-1:0]     out_data,
    input  cbl_pkg::cmd_t                      cmd,
    output cbl_pkg::stat_t                     st
);
    import cbl_pkg::*;

    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LW = IW + 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int HW = (NUM_CASES > 1) ? $clog2(NUM_CASES) : 1;
    localparam logic [LW-1:0] NONE = '1;

    // element store
    logic [CASE_W-1:0] case_mem [MAX_ELEMENTS];
    logic [LW-1:0]     prev_mem [MAX_ELEMENTS];
    logic [LW-1:0]     next_mem [MAX_ELEMENTS];
    // case headers: member count and list head
    logic [CW-1:0]     hmem_cnt  [NUM_CASES];
    logic [LW-1:0]     hmem_head [NUM_CASES];
    logic [NUM_CASES-1:0] hvld_reg;

    logic [CASE_W-1:0] case_q;
    logic [LW-1:0]     prev_q, next_q, head_q;
    logic [CW-1:0]     cnt_q;

    logic              e_re;
    logic [IW-1:0]     e_raddr;
    logic              cw_en, pw_en, nw_en, hw_en, h_re;
    logic [IW-1:0]     cw_addr, pw_addr, nw_addr;
    logic [CASE_W-1:0] cw_data;
    logic [LW-1:0]     pw_data, nw_data, hw_head;
    logic [CW-1:0]     hw_cnt;
    logic [HW-1:0]     hw_addr, h_raddr;

    logic [ACTION_W-1:0] act_reg;
    logic [ELEM_W-1:0]   e1_reg, e2_reg;
    logic [CASE_W-1:0]   cv_reg, av_reg, av_next, v1_reg, v1_next, v2_reg, v2_next;
    logic [NCOUNT_W-1:0] nc_reg;
    logic [CASE_W-1:0]   base_reg;
    logic [CW-1:0]       total_reg, total_next;
    logic [IW-1:0]       ae_reg, ae_next, last_reg, last_next;
    logic [LW-1:0]       p_reg, p_next, n_reg, n_next;
    logic [HW-1:0]       h_reg, h_next;
    logic                second_reg, second_next;
    logic [CASE_W-1:0]   rd_reg, rd_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [LW-1:0]       found_reg, found_next;
    logic [ERR_W-1:0]    err_reg, err_next;
    logic                out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                accept;
    logic [IW-1:0]       e1_idx, e2_idx, total_idx;
    logic [OUTCNT_W-1:0] found_o;

    function automatic logic hdr_ok(input logic [CASE_W-1:0] v, input logic [CASE_W-1:0] b);
        logic [CASE_W-1:0] d;
        d = v - b;
        return (v != '0) && (v >= b) && ({1'b0, d} < (CASE_W+1)'(NUM_CASES));
    endfunction

    function automatic logic case_ok(input logic [CASE_W-1:0] v, input logic [CASE_W-1:0] b);
        return (v == '0) || hdr_ok(v, b);
    endfunction

    function automatic logic [HW-1:0] hdr_idx(input logic [CASE_W-1:0] v,
                                              input logic [CASE_W-1:0] b);
        logic [CASE_W-1:0] d;
        d = v - b;
        return d[HW-1:0];
    endfunction

    assign accept    = (cmd.op == OP_IDLE) && in_valid;
    assign e1_idx    = IW'(e1_reg);
    assign e2_idx    = IW'(e2_reg);
    assign total_idx = IW'(total_reg);

    // status towards the controller
    always_comb
    begin
        st.act       = act_reg;
        st.rng1      = 32'(e1_reg) >= 32'(total_reg);
        st.rng2      = 32'(e2_reg) >= 32'(total_reg);
        st.full      = 32'(total_reg) >= 32'(MAX_ELEMENTS);
        st.nc_over   = 32'(nc_reg) > 32'(MAX_ELEMENTS);
        st.grow      = 32'(nc_reg) > 32'(total_reg);
        st.grow_last = (32'(total_reg) + 32'd1) >= 32'(nc_reg);
        st.cv_zero   = (cv_reg == '0);
        st.cv_hdr_ok = hdr_ok(cv_reg, base_reg);
        st.set_same  = (case_q == cv_reg);
        st.set_ok    = case_ok(cv_reg, base_reg);
        st.sw_same   = (v1_reg == case_q);
        st.sw_ok     = case_ok(v1_reg, base_reg) && case_ok(case_q, base_reg);
        st.cur_same  = (case_q == av_reg);
        st.cur_hdr   = hdr_ok(case_q, base_reg);
        st.av_hdr    = hdr_ok(av_reg, base_reg);
        st.last_done = (total_reg == CW'(1)) || (32'(e1_reg) == 32'(total_reg) - 32'd1);
        st.fix_hdr   = (p_reg == NONE) && hdr_ok(v1_reg, base_reg);
        st.second    = second_reg;
        st.out_free  = !out_vld_reg || out_ready;
    end

    always_comb
    begin
        e_re = 1'b0; e_raddr = e1_idx;
        h_re = 1'b0; h_raddr = h_reg;
        cw_en = 1'b0; cw_addr = ae_reg; cw_data = '0;
        pw_en = 1'b0; pw_addr = ae_reg; pw_data = NONE;
        nw_en = 1'b0; nw_addr = ae_reg; nw_data = NONE;
        hw_en = 1'b0; hw_addr = h_reg; hw_cnt = cnt_q; hw_head = head_q;
        total_next  = total_reg;
        ae_next     = ae_reg;
        av_next     = av_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        last_next   = last_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        h_next      = h_reg;
        second_next = second_reg;
        rd_next     = rd_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        err_next    = err_reg;

        case (cmd.op)
            OP_IDLE:
            begin
                if (in_valid)
                begin
                    rd_next     = '0;
                    cnt_next    = '0;
                    found_next  = NONE;
                    err_next    = ERR_OK;
                    second_next = 1'b0;
                end
            end
            OP_DECODE:
            begin
                case (act_reg)
                    ACT_APPEND:
                    begin
                        if (st.full)
                            err_next = ERR_FULL;
                        else
                        begin
                            cw_en = 1'b1; pw_en = 1'b1; nw_en = 1'b1;
                            cw_addr = total_idx; pw_addr = total_idx; nw_addr = total_idx;
                            total_next = total_reg + CW'(1);
                        end
                    end
                    ACT_RESIZE:
                    begin
                        if (st.nc_over)
                            err_next = ERR_FULL;
                        else if (!st.grow)
                            total_next = CW'(nc_reg);
                    end
                    ACT_SET, ACT_REMOVE, ACT_GET, ACT_NEXT:
                    begin
                        if (st.rng1)
                            err_next = ERR_RANGE;
                        else
                        begin
                            e_re    = 1'b1;
                            ae_next = e1_idx;
                            av_next = cv_reg;
                        end
                    end
                    ACT_COUNT:
                    begin
                        if (!st.cv_zero)
                        begin
                            if (!st.cv_hdr_ok)
                                err_next = ERR_CASE;
                            else
                            begin
                                h_re = 1'b1;
                                h_raddr = hdr_idx(cv_reg, base_reg);
                            end
                        end
                    end
                    ACT_FIRST:
                    begin
                        if (!st.cv_hdr_ok)
                            err_next = ERR_CASE;
                        else
                        begin
                            h_re = 1'b1;
                            h_raddr = hdr_idx(cv_reg, base_reg);
                        end
                    end
                    ACT_SWAP:
                    begin
                        if (st.rng1 || st.rng2)
                            err_next = ERR_RANGE;
                        else
                            e_re = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_GROW:
            begin
                cw_en = 1'b1; pw_en = 1'b1; nw_en = 1'b1;
                cw_addr = total_idx; pw_addr = total_idx; nw_addr = total_idx;
                total_next = total_reg + CW'(1);
            end
            OP_GET:   rd_next = case_q;
            OP_NEXT:  found_next = next_q;
            OP_CNT:   cnt_next = cnt_q;
            OP_FIRST: found_next = head_q;
            OP_SET_CHK:
            begin
                if (!st.set_same && !st.set_ok)
                    err_next = ERR_CASE;
            end
            OP_SW_RD2:
            begin
                v1_next = case_q;
                e_re    = 1'b1;
                e_raddr = e2_idx;
            end
            OP_SW_CHK:
            begin
                v2_next = case_q;
                if (!st.sw_same)
                begin
                    if (!st.sw_ok)
                        err_next = ERR_CASE;
                    else
                    begin
                        ae_next     = e2_idx;
                        av_next     = v1_reg;
                        second_next = 1'b1;
                    end
                end
            end
            OP_A_RD:
            begin
                e_re    = 1'b1;
                e_raddr = ae_reg;
            end
            OP_A_CUR, OP_R_CUR:
            begin
                p_next = prev_q;
                n_next = next_q;
                h_next = hdr_idx(case_q, base_reg);
                if (st.cur_hdr && !(cmd.op == OP_A_CUR && st.cur_same))
                begin
                    h_re    = 1'b1;
                    h_raddr = hdr_idx(case_q, base_reg);
                end
            end
            OP_U_HDR:
            begin
                // take the element out of its list
                hw_en   = 1'b1;
                hw_cnt  = (cnt_q != '0) ? cnt_q - CW'(1) : cnt_q;
                hw_head = (head_q == LW'(ae_reg)) ? n_reg : head_q;
                if (head_q != LW'(ae_reg) && p_reg != NONE)
                begin
                    nw_en   = 1'b1;
                    nw_addr = p_reg[IW-1:0];
                    nw_data = n_reg;
                end
                if (n_reg != NONE)
                begin
                    pw_en   = 1'b1;
                    pw_addr = n_reg[IW-1:0];
                    pw_data = p_reg;
                end
            end
            OP_A_LINK:
            begin
                pw_en   = 1'b1;
                cw_en   = 1'b1;
                cw_data = av_reg;
                h_next  = hdr_idx(av_reg, base_reg);
                if (st.av_hdr)
                begin
                    h_re    = 1'b1;
                    h_raddr = hdr_idx(av_reg, base_reg);
                end
                else
                    nw_en = 1'b1;
            end
            OP_A_HEAD:
            begin
                // push at the list head
                nw_en   = 1'b1;
                nw_data = head_q;
                if (head_q != NONE)
                begin
                    pw_en   = 1'b1;
                    pw_addr = head_q[IW-1:0];
                    pw_data = LW'(ae_reg);
                end
                hw_en   = 1'b1;
                hw_head = LW'(ae_reg);
                hw_cnt  = (cnt_q < CW'(MAX_ELEMENTS)) ? cnt_q + CW'(1) : cnt_q;
            end
            OP_A_END:
            begin
                if (second_reg)
                begin
                    second_next = 1'b0;
                    ae_next     = e1_idx;
                    av_next     = v2_reg;
                end
            end
            OP_R_MOVE:
            begin
                total_next = total_reg - CW'(1);
                last_next  = IW'(total_reg - CW'(1));
                if (!st.last_done)
                begin
                    e_re    = 1'b1;
                    e_raddr = IW'(total_reg - CW'(1));
                end
            end
            OP_R_LAST:
            begin
                // last element moves into the freed slot
                cw_en = 1'b1; cw_addr = e1_idx; cw_data = case_q;
                pw_en = 1'b1; pw_addr = e1_idx; pw_data = prev_q;
                nw_en = 1'b1; nw_addr = e1_idx; nw_data = next_q;
                v1_next = case_q;
                p_next  = prev_q;
                n_next  = next_q;
            end
            OP_R_FIX:
            begin
                if (p_reg != NONE)
                begin
                    nw_en   = 1'b1;
                    nw_addr = p_reg[IW-1:0];
                    nw_data = LW'(e1_idx);
                end
                if (n_reg != NONE)
                begin
                    pw_en   = 1'b1;
                    pw_addr = n_reg[IW-1:0];
                    pw_data = LW'(e1_idx);
                end
                h_next = hdr_idx(v1_reg, base_reg);
                if (st.fix_hdr)
                begin
                    h_re    = 1'b1;
                    h_raddr = hdr_idx(v1_reg, base_reg);
                end
            end
            OP_R_HEAD:
            begin
                if (head_q == LW'(last_reg))
                begin
                    hw_en   = 1'b1;
                    hw_head = LW'(e1_idx);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
            case_mem[cw_addr] <= cw_data;
        if (e_re)
            case_q <= case_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
            prev_mem[pw_addr] <= pw_data;
        if (e_re)
            prev_q <= prev_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nw_en)
            next_mem[nw_addr] <= nw_data;
        if (e_re)
            next_q <= next_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            hmem_cnt[hw_addr]  <= hw_cnt;
            hmem_head[hw_addr] <= hw_head;
        end
        if (h_re)
        begin
            cnt_q  <= hvld_reg[h_raddr] ? hmem_cnt[h_raddr] : '0;
            head_q <= hvld_reg[h_raddr] ? hmem_head[h_raddr] : NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hvld_reg <= '0;
        else if (hw_en)
            hvld_reg[hw_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= in_data[3:0];
            e1_reg  <= in_data[13:4];
            e2_reg  <= in_data[23:14];
            cv_reg  <= in_data[55:24];
            nc_reg  <= in_data[66:56];
        end
        ae_reg     <= ae_next;
        av_reg     <= av_next;
        v1_reg     <= v1_next;
        v2_reg     <= v2_next;
        last_reg   <= last_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        h_reg      <= h_next;
        rd_reg     <= rd_next;
        cnt_reg    <= cnt_next;
        found_reg  <= found_next;
        err_reg    <= err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= CASE_W'(1);
            total_reg   <= '0;
            second_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                base_reg <= cfg_data;
            total_reg  <= total_next;
            second_reg <= second_next;
            if (cmd.op == OP_FIN && st.out_free)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    assign found_o = (found_reg == NONE) ? '1 : OUTCNT_W'(found_reg[IW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FIN && st.out_free)
            out_data_reg <= {5'b0, err_reg, OUTCNT_W'(total_reg), found_o,
                             OUTCNT_W'(cnt_reg), rd_reg};
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(MAX_ELEMENTS))
        else $error("element total above capacity");

    a_grow_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_GROW) |=> (total_reg == $past(total_reg) + CW'(1)))
        else $error("growth step did not advance the total");

    a_hdr_write: assert property (@(posedge clk) disable iff (!rst_n)
        hw_en |-> (cmd.op == OP_U_HDR || cmd.op == OP_A_HEAD || cmd.op == OP_R_HEAD))
        else $error("header written outside a link update");

    a_no_dual_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(e_re && cw_en && (e_raddr == cw_addr)))
        else $error("element read collides with a write");

endmodule

/* rtl/case_bucket_linked_list_table.sv */
// Table of up to MAX_ELEMENTS elements, each carrying a case value, with one
// doubly linked member list per case. One request is processed at a time; the
// result waits in an output register, so the next request is taken while it
// is pending. Resize growth writes one new entry per cycle.
// Element storage has no reset: entries hold valid data once appended or
// grown. Case headers reset to an empty list with zero members.
module case_bucket_linked_list_table #(
    parameter int MAX_ELEMENTS = cbl_pkg::MAX_ELEMENTS_DEF,
    parameter int NUM_CASES    = cbl_pkg::NUM_CASES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cbl_pkg::CASE_W-1:0]      cfg_data,      // case_base
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // action[3:0], element_index[13:4], other_index[23:14],
    // case_value[55:24], new_count[66:56]
    input  logic [cbl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_case[31:0], member_count[42:32], found_index[53:43],
    // table_size[64:54], error_code[66:65]
    output logic [cbl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import cbl_pkg::*;

    cmd_t  cmd;
    stat_t st;

    assign cfg_ready = 1'b1;

    cbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    cbl_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .NUM_CASES    (NUM_CASES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

/* tb/tb_case_bucket_linked_list_table.sv */
`timescale 1ns / 100ps

import cbl_pkg::*;

class bucket_scoreboard;
    localparam int NELEM = MAX_ELEMENTS_DEF;
    localparam int NCASE = NUM_CASES_DEF;

    bit [31:0] elem_case [NELEM];
    int        prev_link [NELEM];
    int        next_link [NELEM];
    int        head_of_case [NCASE];
    int        members [NCASE];
    int        total;
    bit [31:0] base;

    typedef struct {
        bit [31:0] rd_case;
        bit [10:0] mcount;
        bit [10:0] found;
        bit [10:0] tsize;
        bit [1:0]  err;
    } reply_t;

    reply_t pending_replies[$];
    int     mismatches;
    int     replies_checked;
    int     err_seen[4];

    function new();
        total = 0;
        base  = 1;
        mismatches = 0;
        replies_checked = 0;
        for (int i = 0; i < NCASE; i++)
        begin
            head_of_case[i] = -1;
            members[i] = 0;
        end
    endfunction

    function int outstanding();
        return pending_replies.size();
    endfunction

    function bit in_range(int i);
        return i >= 0 && i < NELEM;
    endfunction

    function int bucket_of(bit [31:0] v);
        longint d;
        if (v == 0 || v < base)
            return -1;
        d = longint'(v) - longint'(base);
        if (d >= NCASE)
            return -1;
        return int'(d);
    endfunction

    function bit case_valid(bit [31:0] v);
        return v == 0 || bucket_of(v) >= 0;
    endfunction

    function void clear_entry(int e);
        elem_case[e] = 0;
        prev_link[e] = -1;
        next_link[e] = -1;
    endfunction

    function void detach(int h, int e);
        int p;
        int n;
        p = prev_link[e];
        n = next_link[e];
        if (head_of_case[h] == e)
            head_of_case[h] = n;
        else if (in_range(p))
            next_link[p] = n;
        if (in_range(n))
            prev_link[n] = p;
        if (members[h] > 0)
            members[h]--;
    endfunction

    function void move_to_case(int e, bit [31:0] v);
        int hc;
        int hd;
        int first;
        if (elem_case[e] == v)
            return;
        hc = bucket_of(elem_case[e]);
        hd = bucket_of(v);
        if (hc >= 0)
            detach(hc, e);
        prev_link[e] = -1;
        elem_case[e] = v;
        if (hd >= 0)
        begin
            first = head_of_case[hd];
            next_link[e] = first;
            if (in_range(first))
                prev_link[first] = e;
            head_of_case[hd] = e;
            if (members[hd] < NELEM)
                members[hd]++;
        end
        else
            next_link[e] = -1;
    endfunction

    function void drop_element(int e);
        int last;
        int hc;
        int h;
        last = total - 1;
        hc = bucket_of(elem_case[e]);
        if (hc >= 0)
            detach(hc, e);
        total = last;
        if (total == 0 || e == last)
            return;
        elem_case[e] = elem_case[last];
        prev_link[e] = prev_link[last];
        next_link[e] = next_link[last];
        if (in_range(prev_link[e]))
            next_link[prev_link[e]] = e;
        else
        begin
            h = bucket_of(elem_case[e]);
            if (h >= 0 && head_of_case[h] == last)
                head_of_case[h] = e;
        end
        if (in_range(next_link[e]))
            prev_link[next_link[e]] = e;
    endfunction

    // Accepted request: update the table copy and queue the expected reply.
    function void note_request(bit [3:0] act, int e1, int e2, bit [31:0] cv, int nc);
        reply_t r;
        int h;
        bit [31:0] v1;
        bit [31:0] v2;
        r.rd_case = 0;
        r.mcount = 0;
        r.err = ERR_OK;
        h = -1;
        v1 = 0;
        v2 = 0;
        r.found = '1;
        case (act)
            ACT_APPEND:
                if (total >= NELEM)
                    r.err = ERR_FULL;
                else
                begin
                    clear_entry(total);
                    total++;
                end
            ACT_RESIZE:
                if (nc > NELEM)
                    r.err = ERR_FULL;
                else
                begin
                    for (int i = total; i < nc; i++)
                        clear_entry(i);
                    total = nc;
                end
            ACT_SET:
                if (e1 >= total)
                    r.err = ERR_RANGE;
                else if (elem_case[e1] != cv && !case_valid(cv))
                    r.err = ERR_CASE;
                else
                    move_to_case(e1, cv);
            ACT_REMOVE:
                if (e1 >= total)
                    r.err = ERR_RANGE;
                else
                    drop_element(e1);
            ACT_GET:
                if (e1 >= total)
                    r.err = ERR_RANGE;
                else
                    r.rd_case = elem_case[e1];
            ACT_COUNT:
                if (cv != 0)
                begin
                    h = bucket_of(cv);
                    if (h < 0)
                        r.err = ERR_CASE;
                    else
                        r.mcount = 11'(members[h]);
                end
            ACT_FIRST:
            begin
                h = bucket_of(cv);
                if (h < 0)
                    r.err = ERR_CASE;
                else
                    r.found = 11'(head_of_case[h]);
            end
            ACT_NEXT:
                if (e1 >= total)
                    r.err = ERR_RANGE;
                else
                    r.found = 11'(next_link[e1]);
            ACT_SWAP:
                if (e1 >= total || e2 >= total)
                    r.err = ERR_RANGE;
                else
                begin
                    v1 = elem_case[e1];
                    v2 = elem_case[e2];
                    if (v1 != v2)
                    begin
                        if (!case_valid(v1) || !case_valid(v2))
                            r.err = ERR_CASE;
                        else
                        begin
                            move_to_case(e2, v1);
                            move_to_case(e1, v2);
                        end
                    end
                end
            default: ;
        endcase
        r.tsize = 11'(total);
        err_seen[r.err]++;
        pending_replies.push_back(r);
    endfunction

    function void check_reply(bit [OUT_DATA_W-1:0] d);
        reply_t x;
        if (pending_replies.size() == 0)
        begin
            $error("reply with no request outstanding: %h", d);
            mismatches++;
            return;
        end
        x = pending_replies.pop_front();
        replies_checked++;
        if (d[31:0] != x.rd_case)
        begin
            $error("read_case exp %0d got %0d", x.rd_case, d[31:0]);
            mismatches++;
        end
        if (d[42:32] != x.mcount)
        begin
            $error("member_count exp %0d got %0d", x.mcount, d[42:32]);
            mismatches++;
        end
        if (d[53:43] != x.found)
        begin
            $error("found_index exp %0d got %0d", $signed(x.found), $signed(d[53:43]));
            mismatches++;
        end
        if (d[64:54] != x.tsize)
        begin
            $error("table_size exp %0d got %0d", x.tsize, d[64:54]);
            mismatches++;
        end
        if (d[66:65] != x.err)
        begin
            $error("error_code exp %0d got %0d", x.err, d[66:65]);
            mismatches++;
        end
    endfunction
endclass

module tb_case_bucket_linked_list_table;
    localparam int IDLE_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CASE_W-1:0]     cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    bucket_scoreboard sb;
    bit               hold_sink;
    bit               pacing;
    int               idle_cycles;
    int               sent;

    case_bucket_linked_list_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Any handshake counts as progress.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request.
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_axis_tready = 1'b0;
                repeat (300) @(negedge clk);
                hold_sink = 0;
            end
            wait_n = pacing ? $urandom_range(0, 3) : 0;
            if (wait_n > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_reply(m_axis_tdata);
        end
    end

    task automatic write_base(bit [31:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge clk); while (!cfg_ready);
        sb.base = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_request(bit [3:0] act, int e1, int e2, bit [31:0] cv, int nc);
        int gap;
        gap = pacing ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {5'b0, nc[10:0], cv, e2[9:0], e1[9:0], act};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(act, e1, e2, cv, nc);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int pick_elem();
        if (sb.total > 0 && $urandom_range(0, 99) < 88)
            return $urandom_range(0, sb.total - 1);
        return $urandom_range(0, 1023);
    endfunction

    function automatic bit [31:0] pick_case();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 85)
            return sb.base + $urandom_range(0, 63);
        if (r < 92)
            return sb.base + 64;
        return $urandom();
    endfunction

    task automatic random_request();
        int r;
        int nc;
        r = $urandom_range(0, 99);
        if (r < 2)
            send_request($urandom_range(9, 15), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), $urandom(), $urandom_range(0, 2047));
        else if (r < 4 || sb.total < 8)
            send_request(ACT_APPEND, pick_elem(), pick_elem(), $urandom(), 0);
        else if (r < 7)
        begin
            nc = $urandom_range(0, 99) < 90 ? $urandom_range(0, 80)
                 : ($urandom_range(0, 3) == 0 ? 1024 : $urandom_range(0, 2047));
            send_request(ACT_RESIZE, pick_elem(), pick_elem(), $urandom(), nc);
        end
        else if (r < 35)
            send_request(ACT_SET, pick_elem(), pick_elem(), pick_case(), 0);
        else if (r < 42)
            send_request(ACT_REMOVE, pick_elem(), pick_elem(), pick_case(), 0);
        else if (r < 52)
            send_request(ACT_GET, pick_elem(), pick_elem(), pick_case(), 0);
        else if (r < 60)
            send_request(ACT_COUNT, pick_elem(), pick_elem(), pick_case(), 0);
        else if (r < 68)
            send_request(ACT_FIRST, pick_elem(), pick_elem(), pick_case(), 0);
        else if (r < 80)
            send_request(ACT_NEXT, pick_elem(), pick_elem(), pick_case(), 0);
        else
            send_request(ACT_SWAP, pick_elem(), pick_elem(), pick_case(), 0);
    endtask

    initial
    begin
        bit [31:0] bases[6];
        sb = new();
        hold_sink = 0;
        pacing = 0;
        sent = 0;
        bases = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFC1, 32'd0, 32'd100, 32'd1};
        bases[3] = $urandom_range(2, 32'h7FFF_FFFF);
        @(posedge rst_n);
        write_base(32'd1);

        // directed: boundaries, every action, error paths
        send_request(ACT_GET, 0, 0, 0, 0);
        send_request(ACT_RESIZE, 0, 0, 0, 1025);
        send_request(ACT_RESIZE, 0, 0, 0, 1024);
        send_request(ACT_APPEND, 0, 0, 0, 0);
        send_request(ACT_GET, 1023, 0, 0, 0);
        send_request(ACT_RESIZE, 0, 0, 0, 4);
        send_request(ACT_SET, 0, 0, 32'd1, 0);
        send_request(ACT_SET, 1, 0, 32'd1, 0);
        send_request(ACT_SET, 2, 0, 32'd64, 0);
        send_request(ACT_SET, 3, 0, 32'd65, 0);
        send_request(ACT_SET, 0, 0, 32'd1, 0);
        send_request(ACT_FIRST, 0, 0, 32'd1, 0);
        send_request(ACT_NEXT, 1, 0, 0, 0);
        send_request(ACT_COUNT, 0, 0, 32'd1, 0);
        send_request(ACT_COUNT, 0, 0, 32'd0, 0);
        send_request(ACT_FIRST, 0, 0, 32'd0, 0);
        send_request(ACT_SWAP, 1, 2, 0, 0);
        send_request(ACT_SWAP, 1, 1023, 0, 0);
        send_request(ACT_REMOVE, 1, 0, 0, 0);
        send_request(ACT_REMOVE, 2, 0, 0, 0);
        send_request(ACT_SET, 0, 0, 32'd0, 0);
        send_request(ACT_GET, 0, 0, 0, 0);
        send_request(4'd9, 0, 0, 0, 0);
        send_request(4'd15, 1023, 1023, 32'hFFFF_FFFF, 2047);
        drain();

        pacing = 1;
        foreach (bases[p])
        begin
            // case values assigned earlier go stale once the base moves
            write_base(bases[p]);
            for (int i = 0; i < 288; i++)
            begin
                if (p == 1 && i == 40)
                    hold_sink = 1;
                if (p == 2 && i == 100)
                begin
                    @(negedge clk);
                    s_axis_tvalid = 1'b0;
                    while (sb.outstanding() != 0)
                        @(posedge clk);
                end
                random_request();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Run: %0d requests over %0d base settings, %0d replies checked",
                 sent, 7, sb.replies_checked);
        $display("Error codes seen: ok %0d, range %0d, case %0d, full %0d",
                 sb.err_seen[0], sb.err_seen[1], sb.err_seen[2], sb.err_seen[3]);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* files.f */
rtl/cbl_pkg.sv
rtl/cbl_ctrl.sv
rtl/cbl_dp.sv
rtl/case_bucket_linked_list_table.sv
tb/tb_case_bucket_linked_list_table.sv
